[src/grct_pkg.sv]
package grct_pkg;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDX_MUL,
    OP_IDX_DIV,
    OP_IDX_STORE,
    OP_FACE_MUL,
    OP_FACE_DIV,
    OP_FACE_STORE,
    OP_FACE_Z,
    OP_SEL_TAKE,
    OP_CMP_M1,
    OP_CMP_M2,
    OP_CMP,
    OP_EX_NEAR,
    OP_EX_MUL,
    OP_EX_DIV,
    OP_EX_STORE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ax_clr;
    logic ax_inc;
  } cmd_t;

  typedef struct packed {
    logic       in_box;
    logic       moving;
    logic       div_busy;
    logic [1:0] ax;
    logic       v_zero;
    logic       best_none;
    logic       ax_is_best;
    logic       last;
    logic       out_free;
  } stat_t;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_END  = 2'd3;
  localparam logic [1:0] AX_NONE = 2'd3;

  localparam logic [2:0] REG_MIN_X  = 3'd0;
  localparam logic [2:0] REG_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_MIN_Z  = 3'd2;
  localparam logic [2:0] REG_SIZE_X = 3'd3;
  localparam logic [2:0] REG_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_SIZE_Z = 3'd5;
  localparam logic [2:0] REG_COLS   = 3'd6;
  localparam logic [2:0] REG_ROWS   = 3'd7;

  localparam logic [5:0] LAST_CELL_NUM = 6'd62;

endpackage

[src/grct_div.sv]
module grct_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  assign shifted = {rem, quotient[63]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 6'd1;
      if (count == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[62:0], ge};
      rem      <= ge ? diff[31:0] : shifted[31:0];
    end
  end

endmodule

[src/grct_ctrl.sv]
module grct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  grct_pkg::stat_t       stat,
  output grct_pkg::cmd_t        cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_CHECK     = 17'h00002,
    S_IDX_MUL   = 17'h00004,
    S_IDX_DIV   = 17'h00008,
    S_IDX_WAIT  = 17'h00010,
    S_FACE_MUL  = 17'h00020,
    S_FACE_DIV  = 17'h00040,
    S_FACE_WAIT = 17'h00080,
    S_FACE_Z    = 17'h00100,
    S_SEL       = 17'h00200,
    S_CMP_M1    = 17'h00400,
    S_CMP_M2    = 17'h00800,
    S_CMP       = 17'h01000,
    S_EX        = 17'h02000,
    S_EX_DIV    = 17'h04000,
    S_EX_WAIT   = 17'h08000,
    S_EMIT      = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = grct_pkg::OP_NONE;
    cmd.ax_clr = 1'b0;
    cmd.ax_inc = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = grct_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.ax_clr = 1'b1;
        state_next = (stat.in_box && stat.moving) ? S_IDX_MUL : S_IDLE;
      end
      S_IDX_MUL: begin
        cmd.op     = grct_pkg::OP_IDX_MUL;
        state_next = S_IDX_DIV;
      end
      S_IDX_DIV: begin
        cmd.op     = grct_pkg::OP_IDX_DIV;
        state_next = S_IDX_WAIT;
      end
      S_IDX_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op = grct_pkg::OP_IDX_STORE;
          if (stat.ax == grct_pkg::AX_Y) begin
            cmd.ax_clr = 1'b1;
            state_next = S_FACE_MUL;
          end else begin
            cmd.ax_inc = 1'b1;
            state_next = S_IDX_MUL;
          end
        end
      end
      S_FACE_MUL: begin
        cmd.op     = grct_pkg::OP_FACE_MUL;
        state_next = S_FACE_DIV;
      end
      S_FACE_DIV: begin
        cmd.op     = grct_pkg::OP_FACE_DIV;
        state_next = S_FACE_WAIT;
      end
      S_FACE_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = grct_pkg::OP_FACE_STORE;
          cmd.ax_inc = 1'b1;
          state_next = (stat.ax == grct_pkg::AX_Y) ? S_FACE_Z : S_FACE_MUL;
        end
      end
      S_FACE_Z: begin
        cmd.op     = grct_pkg::OP_FACE_Z;
        cmd.ax_clr = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (stat.ax == grct_pkg::AX_END) begin
          cmd.ax_clr = 1'b1;
          state_next = S_EX;
        end else if (stat.v_zero) begin
          cmd.ax_inc = 1'b1;
        end else if (stat.best_none) begin
          cmd.op     = grct_pkg::OP_SEL_TAKE;
          cmd.ax_inc = 1'b1;
        end else begin
          state_next = S_CMP_M1;
        end
      end
      S_CMP_M1: begin
        cmd.op     = grct_pkg::OP_CMP_M1;
        state_next = S_CMP_M2;
      end
      S_CMP_M2: begin
        cmd.op     = grct_pkg::OP_CMP_M2;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op     = grct_pkg::OP_CMP;
        cmd.ax_inc = 1'b1;
        state_next = S_SEL;
      end
      S_EX: begin
        if (stat.ax == grct_pkg::AX_END) begin
          state_next = S_EMIT;
        end else if (stat.ax_is_best) begin
          cmd.op     = grct_pkg::OP_EX_NEAR;
          cmd.ax_inc = 1'b1;
        end else begin
          cmd.op     = grct_pkg::OP_EX_MUL;
          state_next = S_EX_DIV;
        end
      end
      S_EX_DIV: begin
        cmd.op     = grct_pkg::OP_EX_DIV;
        state_next = S_EX_WAIT;
      end
      S_EX_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = grct_pkg::OP_EX_STORE;
          cmd.ax_inc = 1'b1;
          state_next = S_EX;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = grct_pkg::OP_EMIT;
          cmd.ax_clr = 1'b1;
          state_next = stat.last ? S_IDLE : S_FACE_MUL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/grct_dp.sv]
module grct_dp #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [191:0]          s_tdata,
  input  grct_pkg::cmd_t        cmd,
  output grct_pkg::stat_t       stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [111:0]          m_tdata,
  output logic                  m_tlast
);

  localparam logic [5:0] MAXC = 6'(MAX_COLS);
  localparam logic [5:0] MAXR = 6'(MAX_ROWS);

  function automatic logic [31:0] sat35(input logic signed [34:0] s);
    logic [31:0] r;
    if (s > 35'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (s < -35'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic [30:0] dist_of(input logic [30:0] f, input logic [30:0] o,
                                          input logic neg);
    logic [30:0] r;
    if (!neg) begin
      r = (f >= o) ? f - o : '0;
    end else begin
      r = (o >= f) ? o - f : '0;
    end
    return r;
  endfunction

  function automatic logic [5:0] clamp_cnt(input logic [5:0] c, input logic [5:0] m);
    logic [5:0] r;
    if (c == 6'd0) begin
      r = 6'd1;
    end else if (c > m) begin
      r = m;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [31:0] cfg_min [3];
  logic [30:0]        cfg_size [3];
  logic [5:0]         cfg_cols;
  logic [5:0]         cfg_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < 3; l++) begin
        cfg_min[l]  <= '0;
        cfg_size[l] <= 31'd65536;
      end
      cfg_cols <= 6'd32;
      cfg_rows <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grct_pkg::REG_MIN_X:  cfg_min[0]  <= cfg_data;
        grct_pkg::REG_MIN_Y:  cfg_min[1]  <= cfg_data;
        grct_pkg::REG_MIN_Z:  cfg_min[2]  <= cfg_data;
        grct_pkg::REG_SIZE_X: cfg_size[0] <= cfg_data[30:0];
        grct_pkg::REG_SIZE_Y: cfg_size[1] <= cfg_data[30:0];
        grct_pkg::REG_SIZE_Z: cfg_size[2] <= cfg_data[30:0];
        grct_pkg::REG_COLS:   cfg_cols    <= cfg_data[5:0];
        grct_pkg::REG_ROWS:   cfg_rows    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Ray registers.
  logic signed [31:0] p [3];
  logic signed [31:0] v [3];
  logic signed [31:0] lo [3];
  logic [30:0]        off [3];
  logic [31:0]        av [3];
  logic [30:0]        sz [3];
  logic [30:0]        face [3];
  logic [30:0]        fdist [3];
  logic [31:0]        ex [3];
  logic [5:0]         cnt_x;
  logic [5:0]         cnt_y;
  logic [4:0]         idx_x;
  logic [4:0]         idx_y;
  logic               in_box;
  logic               moving;
  logic [1:0]         ax;
  logic [1:0]         axi;
  logic [1:0]         best;
  logic [30:0]        bdist;
  logic [31:0]        bav;
  logic               bneg;
  logic [63:0]        prod;
  logic [63:0]        p1;
  logic [5:0]         n;

  // Load-time values.
  logic [30:0] ld_off [3];
  logic [31:0] ld_av [3];
  logic [30:0] ld_sz [3];
  logic        ld_inside;
  logic        ld_moving;

  always_comb begin
    logic signed [32:0] d;
    logic [31:0]        pin;
    logic [31:0]        vin;
    ld_inside = 1'b1;
    ld_moving = 1'b0;
    for (int l = 0; l < 3; l++) begin
      pin       = s_tdata[32*l +: 32];
      vin       = s_tdata[32*(l+3) +: 32];
      ld_sz[l]  = (cfg_size[l] == '0) ? 31'd1 : cfg_size[l];
      d         = $signed({pin[31], pin}) - $signed({cfg_min[l][31], cfg_min[l]});
      if (d[32] || (d[31:0] > {1'b0, ld_sz[l]})) begin
        ld_inside = 1'b0;
      end
      ld_off[l] = d[30:0];
      ld_av[l]  = vin[31] ? (32'd0 - vin) : vin;
      if (vin != '0) begin
        ld_moving = 1'b1;
      end
    end
  end

  assign axi = (ax == grct_pkg::AX_END) ? grct_pkg::AX_Z : ax;

  // Per-axis selections.
  logic [5:0]  cnt_ax;
  logic [4:0]  idx_ax;
  logic [5:0]  k_face;
  logic [30:0] face_z;

  assign cnt_ax = (axi == grct_pkg::AX_X) ? cnt_x : cnt_y;
  assign idx_ax = (axi == grct_pkg::AX_X) ? idx_x : idx_y;
  assign k_face = v[axi][31] ? {1'b0, idx_ax} : ({1'b0, idx_ax} + 6'd1);
  assign face_z = v[2][31] ? '0 : sz[2];

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_res;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      grct_pkg::OP_IDX_MUL: begin
        mul_a = {1'b0, off[axi]} + 32'd1;
        mul_b = {26'd0, cnt_ax};
      end
      grct_pkg::OP_FACE_MUL: begin
        mul_a = {26'd0, k_face};
        mul_b = {1'b0, sz[axi]};
      end
      grct_pkg::OP_CMP_M1: begin
        mul_a = {1'b0, fdist[axi]};
        mul_b = bav;
      end
      grct_pkg::OP_CMP_M2: begin
        mul_a = {1'b0, bdist};
        mul_b = av[axi];
      end
      grct_pkg::OP_EX_MUL: begin
        mul_a = av[axi];
        mul_b = {1'b0, bdist};
      end
      default: ;
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // Shared divider.
  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_busy;
  logic [63:0] q;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = bav;
    case (cmd.op)
      grct_pkg::OP_IDX_DIV: begin
        div_start    = 1'b1;
        div_dividend = prod - 64'd1;
        div_divisor  = {1'b0, sz[axi]};
      end
      grct_pkg::OP_FACE_DIV: begin
        div_start    = 1'b1;
        div_divisor  = {26'd0, cnt_ax};
      end
      grct_pkg::OP_EX_DIV: begin
        div_start    = 1'b1;
        div_dividend = prod + {33'd0, bav[31:1]};
      end
      default: ;
    endcase
  end

  grct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (q)
  );

  // Exit coordinates.
  logic [4:0]         idx_clamped;
  logic [31:0]        ex_near;
  logic [31:0]        ex_far;
  logic signed [34:0] far_sum;

  assign idx_clamped = (q > {58'd0, cnt_ax - 6'd1}) ? 5'(cnt_ax - 6'd1) : q[4:0];
  assign ex_near     = sat35($signed({{3{lo[axi][31]}}, lo[axi]}) +
                             $signed({4'd0, face[axi]}));
  assign far_sum     = v[axi][31] ?
                       $signed({{3{p[axi][31]}}, p[axi]}) - $signed({2'b0, q[32:0]}) :
                       $signed({{3{p[axi][31]}}, p[axi]}) + $signed({2'b0, q[32:0]});
  assign ex_far      = (q[63:33] != '0) ? (v[axi][31] ? 32'h80000000 : 32'h7fffffff) :
                       sat35(far_sum);

  // Final cell test.
  logic last_now;

  always_comb begin
    case (best)
      grct_pkg::AX_X: last_now = bneg ? (idx_x == 5'd0) : ({1'b0, idx_x} == cnt_x - 6'd1);
      grct_pkg::AX_Y: last_now = bneg ? (idx_y == 5'd0) : ({1'b0, idx_y} == cnt_y - 6'd1);
      default:        last_now = 1'b1;
    endcase
    if (n == grct_pkg::LAST_CELL_NUM) begin
      last_now = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
    end else if (cmd.ax_clr) begin
      ax <= '0;
    end else if (cmd.ax_inc) begin
      ax <= ax + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= grct_pkg::AX_NONE;
    end else if (cmd.op == grct_pkg::OP_FACE_Z) begin
      best <= grct_pkg::AX_NONE;
    end else if ((cmd.op == grct_pkg::OP_SEL_TAKE) ||
                 ((cmd.op == grct_pkg::OP_CMP) && (p1 < prod))) begin
      best <= axi;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      grct_pkg::OP_LOAD: begin
        for (int l = 0; l < 3; l++) begin
          p[l]   <= s_tdata[32*l +: 32];
          v[l]   <= s_tdata[32*(l+3) +: 32];
          lo[l]  <= cfg_min[l];
          off[l] <= ld_off[l];
          av[l]  <= ld_av[l];
          sz[l]  <= ld_sz[l];
        end
        cnt_x  <= clamp_cnt(cfg_cols, MAXC);
        cnt_y  <= clamp_cnt(cfg_rows, MAXR);
        in_box <= ld_inside;
        moving <= ld_moving;
        n      <= '0;
      end
      grct_pkg::OP_IDX_MUL, grct_pkg::OP_FACE_MUL, grct_pkg::OP_CMP_M1,
      grct_pkg::OP_EX_MUL: begin
        prod <= mul_res;
      end
      grct_pkg::OP_CMP_M2: begin
        p1   <= prod;
        prod <= mul_res;
      end
      grct_pkg::OP_IDX_STORE: begin
        if (axi == grct_pkg::AX_X) begin
          idx_x <= idx_clamped;
        end else begin
          idx_y <= idx_clamped;
        end
      end
      grct_pkg::OP_FACE_STORE: begin
        face[axi]  <= q[30:0];
        fdist[axi] <= dist_of(q[30:0], off[axi], v[axi][31]);
      end
      grct_pkg::OP_FACE_Z: begin
        face[2]  <= face_z;
        fdist[2] <= dist_of(face_z, off[2], v[2][31]);
      end
      grct_pkg::OP_SEL_TAKE: begin
        bdist <= fdist[axi];
        bav   <= av[axi];
        bneg  <= v[axi][31];
      end
      grct_pkg::OP_CMP: begin
        if (p1 < prod) begin
          bdist <= fdist[axi];
          bav   <= av[axi];
          bneg  <= v[axi][31];
        end
      end
      grct_pkg::OP_EX_NEAR: begin
        ex[axi] <= ex_near;
      end
      grct_pkg::OP_EX_STORE: begin
        ex[axi] <= ex_far;
      end
      grct_pkg::OP_EMIT: begin
        n <= n + 6'd1;
        if (best == grct_pkg::AX_X) begin
          idx_x <= bneg ? idx_x - 5'd1 : idx_x + 5'd1;
        end else if (best == grct_pkg::AX_Y) begin
          idx_y <= bneg ? idx_y - 5'd1 : idx_y + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == grct_pkg::OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == grct_pkg::OP_EMIT) begin
      m_tdata <= {6'd0, ex[2], ex[1], ex[0], idx_y, idx_x};
      m_tlast <= last_now;
    end
  end

  assign stat.in_box     = in_box;
  assign stat.moving     = moving;
  assign stat.div_busy   = div_busy;
  assign stat.ax         = ax;
  assign stat.v_zero     = (av[axi] == '0);
  assign stat.best_none  = (best == grct_pkg::AX_NONE);
  assign stat.ax_is_best = (ax == best);
  assign stat.last       = last_now;
  assign stat.out_free   = !m_tvalid || m_tready;

  ap_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  ap_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == grct_pkg::OP_EMIT) |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  ap_emit_best: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == grct_pkg::OP_EMIT) |-> (best != grct_pkg::AX_NONE && bav != '0))
    else $error("result emitted without a chosen axis");

endmodule

[src/grid_ray_cell_traversal.sv]
// A ray yields up to 63 cells.
// One shared 64-iteration divider (one quotient bit per cycle) sets the rate: two index
// divisions per ray, then two face positions and two exit offsets per cell.
// One ray is in work at a time; a new ray is accepted once the last cell is in the output register.
// Synchronous active-high reset clears control and output valid, restores a unit box.
module grid_ray_cell_traversal #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_col, cell_row, exit_x, exit_y, exit_z, zero fill
  output logic [111:0] m_tdata,
  output logic         m_tlast
);

  grct_pkg::cmd_t  cmd;
  grct_pkg::stat_t stat;

  grct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  grct_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
